// ===== rtl/rti_pkg.sv =====
// shared constants, types and codes for the ray/triangle intersection pipeline
`timescale 1ns / 1ps

package rti_pkg;

    localparam int COORD_WIDTH     = 32;
    localparam int FRAC_BITS       = 16;
    localparam int MUL_A_WIDTH     = COORD_WIDTH + 2;
    localparam int MUL_B_WIDTH     = 2 * COORD_WIDTH + 4;
    localparam int MUL_SPLIT       = MUL_A_WIDTH;
    localparam int PROD_WIDTH      = MUL_A_WIDTH + MUL_B_WIDTH;
    localparam int DIV_WIDTH       = PROD_WIDTH + COORD_WIDTH;
    localparam int QUOT_WIDTH      = COORD_WIDTH - 1;
    localparam int BARY_WIDTH      = FRAC_BITS + 1;
    localparam int THR_WIDTH       = COORD_WIDTH - 1;
    localparam int CFG_INDEX_WIDTH = 3;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DIR_X    = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DIR_Y    = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DIR_Z    = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MIN_DET  = 3'd6;

    typedef enum logic [2:0] {
        RSN_HIT      = 3'd0,
        RSN_PARALLEL = 3'd1,
        RSN_U_OUT    = 3'd2,
        RSN_V_OUT    = 3'd3,
        RSN_BEHIND   = 3'd4
    } reason_t;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [PROD_WIDTH-1:0]  wide_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vec_t;

    typedef struct packed {
        vec_t origin;
        vec_t dir;
    } ray_t;

    typedef struct packed {
        logic    valid;
        reason_t reason;
    } cls_t;

endpackage

// ===== rtl/rti_mul.sv =====
// two-stage signed multiplier built from two narrow partial products
`timescale 1ns / 1ps

module rti_mul (
    input  logic                                   clk,
    input  logic signed [rti_pkg::MUL_A_WIDTH-1:0] a,
    input  logic signed [rti_pkg::MUL_B_WIDTH-1:0] b,
    output logic signed [rti_pkg::PROD_WIDTH-1:0]  p
);

    localparam int AW   = rti_pkg::MUL_A_WIDTH;
    localparam int LO_W = rti_pkg::MUL_SPLIT;
    localparam int HI_W = rti_pkg::MUL_B_WIDTH - LO_W;
    localparam int PW   = rti_pkg::PROD_WIDTH;

    logic signed [AW+LO_W:0]   lo_next;
    logic signed [AW+LO_W:0]   lo_reg;
    logic signed [AW+HI_W-1:0] hi_next;
    logic signed [AW+HI_W-1:0] hi_reg;
    logic signed [PW-1:0]      p_next;
    logic signed [PW-1:0]      p_reg;

    always_comb
    begin
        // low slice is taken unsigned, high slice carries the sign
        lo_next = a * $signed({1'b0, b[LO_W-1:0]});
        hi_next = a * $signed(b[rti_pkg::MUL_B_WIDTH-1:LO_W]);
        p_next  = (PW'(hi_reg) <<< LO_W) + PW'(lo_reg);
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        p_reg  <= p_next;
    end

    assign p = p_reg;

endmodule

// ===== rtl/rti_geom.sv =====
// edge vectors, cross products and the four exact dot products
`timescale 1ns / 1ps

module rti_geom (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  rti_pkg::vec_t  va,
    input  rti_pkg::vec_t  vb,
    input  rti_pkg::vec_t  vc,
    input  rti_pkg::ray_t  ray,
    output logic           out_valid,
    output rti_pkg::wide_t det,
    output rti_pkg::wide_t nu,
    output rti_pkg::wide_t nv,
    output rti_pkg::wide_t nt
);

    localparam int LAT = 7;
    localparam int AW  = rti_pkg::MUL_A_WIDTH;
    localparam int BW  = rti_pkg::MUL_B_WIDTH;

    typedef logic signed [AW-1:0] opa_t;
    typedef logic signed [BW-1:0] opb_t;

    logic [LAT-1:0] vld_reg;
    opa_t           a_in [3];
    opa_t           b_in [3];
    opa_t           c_in [3];
    opa_t           ro   [3];
    opa_t           rd   [3];
    opa_t           e1_reg [3];
    opa_t           e2_reg [3];
    opa_t           s_reg  [3];
    opa_t           e1_dly [3][3];
    opa_t           e2_dly [3][3];
    opa_t           s_dly  [3][3];
    rti_pkg::wide_t pa_prod [3];
    rti_pkg::wide_t pb_prod [3];
    rti_pkg::wide_t qa_prod [3];
    rti_pkg::wide_t qb_prod [3];
    opb_t           p_reg [3];
    opb_t           q_reg [3];
    rti_pkg::wide_t det_prod [3];
    rti_pkg::wide_t nu_prod  [3];
    rti_pkg::wide_t nv_prod  [3];
    rti_pkg::wide_t nt_prod  [3];
    rti_pkg::wide_t det_reg;
    rti_pkg::wide_t nu_reg;
    rti_pkg::wide_t nv_reg;
    rti_pkg::wide_t nt_reg;

    always_comb
    begin
        a_in[0] = AW'($signed(va.x));
        a_in[1] = AW'($signed(va.y));
        a_in[2] = AW'($signed(va.z));
        b_in[0] = AW'($signed(vb.x));
        b_in[1] = AW'($signed(vb.y));
        b_in[2] = AW'($signed(vb.z));
        c_in[0] = AW'($signed(vc.x));
        c_in[1] = AW'($signed(vc.y));
        c_in[2] = AW'($signed(vc.z));
        ro[0]   = AW'($signed(ray.origin.x));
        ro[1]   = AW'($signed(ray.origin.y));
        ro[2]   = AW'($signed(ray.origin.z));
        rd[0]   = AW'($signed(ray.dir.x));
        rd[1]   = AW'($signed(ray.dir.y));
        rd[2]   = AW'($signed(ray.dir.z));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            e1_reg[i]    <= b_in[i] - a_in[i];
            e2_reg[i]    <= c_in[i] - a_in[i];
            s_reg[i]     <= ro[i] - a_in[i];
            e1_dly[0][i] <= e1_reg[i];
            e2_dly[0][i] <= e2_reg[i];
            s_dly[0][i]  <= s_reg[i];
            for (int k = 1; k < 3; k++)
            begin
                e1_dly[k][i] <= e1_dly[k-1][i];
                e2_dly[k][i] <= e2_dly[k-1][i];
                s_dly[k][i]  <= s_dly[k-1][i];
            end
            p_reg[i] <= BW'(pa_prod[i] - pb_prod[i]);
            q_reg[i] <= BW'(qa_prod[i] - qb_prod[i]);
        end
        det_reg <= det_prod[0] + det_prod[1] + det_prod[2];
        nu_reg  <= nu_prod[0] + nu_prod[1] + nu_prod[2];
        nv_reg  <= nv_prod[0] + nv_prod[1] + nv_prod[2];
        nt_reg  <= nt_prod[0] + nt_prod[1] + nt_prod[2];
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_axis
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;

        // p = dir x e2, q = s x e1
        rti_mul u_pa (.clk(clk), .a(rd[J]), .b(BW'(e2_reg[K])), .p(pa_prod[i]));
        rti_mul u_pb (.clk(clk), .a(rd[K]), .b(BW'(e2_reg[J])), .p(pb_prod[i]));
        rti_mul u_qa (.clk(clk), .a(s_reg[J]), .b(BW'(e1_reg[K])), .p(qa_prod[i]));
        rti_mul u_qb (.clk(clk), .a(s_reg[K]), .b(BW'(e1_reg[J])), .p(qb_prod[i]));

        rti_mul u_det (.clk(clk), .a(e1_dly[2][i]), .b(p_reg[i]), .p(det_prod[i]));
        rti_mul u_nu  (.clk(clk), .a(s_dly[2][i]), .b(p_reg[i]), .p(nu_prod[i]));
        rti_mul u_nv  (.clk(clk), .a(rd[i]), .b(q_reg[i]), .p(nv_prod[i]));
        rti_mul u_nt  (.clk(clk), .a(e2_dly[2][i]), .b(q_reg[i]), .p(nt_prod[i]));
    end

    assign out_valid = vld_reg[LAT-1];
    assign det       = det_reg;
    assign nu        = nu_reg;
    assign nv        = nv_reg;
    assign nt        = nt_reg;

endmodule

// ===== rtl/rti_classify.sv =====
// sign normalization and the ordered parallel / u / v / behind tests
`timescale 1ns / 1ps

module rti_classify (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  rti_pkg::wide_t                   det,
    input  rti_pkg::wide_t                   nu,
    input  rti_pkg::wide_t                   nv,
    input  rti_pkg::wide_t                   nt,
    input  logic [rti_pkg::THR_WIDTH-1:0]    min_abs_det,
    output rti_pkg::cls_t                    ctl,
    output rti_pkg::wide_t                   adet,
    output rti_pkg::wide_t                   nu_out,
    output rti_pkg::wide_t                   nv_out,
    output rti_pkg::wide_t                   nt_out
);

    localparam int PW = rti_pkg::PROD_WIDTH;
    localparam int SW = PW + rti_pkg::FRAC_BITS;

    logic [2:0]             vld_reg;
    rti_pkg::wide_t         det1_reg;
    rti_pkg::wide_t         nu1_reg;
    rti_pkg::wide_t         nv1_reg;
    rti_pkg::wide_t         nt1_reg;
    rti_pkg::wide_t         det2_reg;
    rti_pkg::wide_t         nu2_reg;
    rti_pkg::wide_t         nv2_reg;
    rti_pkg::wide_t         nt2_reg;
    logic signed [PW:0]     nuv_next;
    logic signed [PW:0]     nuv_reg;
    logic signed [SW-1:0]   nt_scaled;
    rti_pkg::wide_t         thr;
    logic                   par_next;
    logic                   uout_next;
    logic                   behind_next;
    logic                   par_reg;
    logic                   uout_reg;
    logic                   vneg_reg;
    logic                   behind_reg;
    logic                   vout;
    rti_pkg::reason_t       reason_next;
    rti_pkg::reason_t       reason_reg;
    rti_pkg::wide_t         det3_reg;
    rti_pkg::wide_t         nu3_reg;
    rti_pkg::wide_t         nv3_reg;
    rti_pkg::wide_t         nt3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_comb
    begin
        // threshold is unsigned Q15.16, det carries three times the fraction bits
        thr         = PW'({min_abs_det, {(2 * rti_pkg::FRAC_BITS){1'b0}}});
        par_next    = (det1_reg == '0) || (det1_reg < thr);
        uout_next   = nu1_reg[PW-1] || (nu1_reg > det1_reg);
        nt_scaled   = {nt1_reg, {rti_pkg::FRAC_BITS{1'b0}}};
        behind_next = nt_scaled < SW'(det1_reg);
        nuv_next    = (PW+1)'(nu1_reg) + (PW+1)'(nv1_reg);

        vout = vneg_reg || (nuv_reg > (PW+1)'(det2_reg));
        priority if (par_reg)
            reason_next = rti_pkg::RSN_PARALLEL;
        else if (uout_reg)
            reason_next = rti_pkg::RSN_U_OUT;
        else if (vout)
            reason_next = rti_pkg::RSN_V_OUT;
        else if (behind_reg)
            reason_next = rti_pkg::RSN_BEHIND;
        else
            reason_next = rti_pkg::RSN_HIT;
    end

    always_ff @(posedge clk)
    begin
        // flip all four so that det is non-negative
        if (det[PW-1])
        begin
            det1_reg <= -det;
            nu1_reg  <= -nu;
            nv1_reg  <= -nv;
            nt1_reg  <= -nt;
        end
        else
        begin
            det1_reg <= det;
            nu1_reg  <= nu;
            nv1_reg  <= nv;
            nt1_reg  <= nt;
        end
        par_reg    <= par_next;
        uout_reg   <= uout_next;
        vneg_reg   <= nv1_reg[PW-1];
        behind_reg <= behind_next;
        nuv_reg    <= nuv_next;
        det2_reg   <= det1_reg;
        nu2_reg    <= nu1_reg;
        nv2_reg    <= nv1_reg;
        nt2_reg    <= nt1_reg;
        reason_reg <= reason_next;
        det3_reg   <= det2_reg;
        nu3_reg    <= nu2_reg;
        nv3_reg    <= nv2_reg;
        nt3_reg    <= nt2_reg;
    end

    assign ctl.valid  = vld_reg[2];
    assign ctl.reason = reason_reg;
    assign adet       = det3_reg;
    assign nu_out     = nu3_reg;
    assign nv_out     = nv3_reg;
    assign nt_out     = nt3_reg;

endmodule

// ===== rtl/rti_div.sv =====
// one-bit-per-stage restoring dividers for t, u and v plus result formatting
`timescale 1ns / 1ps

module rti_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rti_pkg::cls_t                     ctl,
    input  rti_pkg::wide_t                    d,
    input  rti_pkg::wide_t                    nt,
    input  rti_pkg::wide_t                    nu,
    input  rti_pkg::wide_t                    nv,
    output logic                              done,
    output logic                              hit,
    output logic [2:0]                        miss_reason,
    output logic [rti_pkg::QUOT_WIDTH-1:0]    hit_distance,
    output logic [rti_pkg::BARY_WIDTH-1:0]    bary_u,
    output logic [rti_pkg::BARY_WIDTH-1:0]    bary_v
);

    localparam int STEPS = rti_pkg::QUOT_WIDTH;
    localparam int LANES = 3;
    localparam int DW    = rti_pkg::DIV_WIDTH;
    localparam int QW    = rti_pkg::QUOT_WIDTH;
    localparam int BW    = rti_pkg::BARY_WIDTH;

    logic [DW-1:0]     r_in   [STEPS][LANES];
    logic [DW-1:0]     r_next [STEPS][LANES];
    logic [DW-1:0]     r_reg  [STEPS][LANES];
    logic [QW-1:0]     q_in   [STEPS][LANES];
    logic [QW-1:0]     q_next [STEPS][LANES];
    logic [QW-1:0]     q_reg  [STEPS][LANES];
    logic              ge     [STEPS][LANES];
    logic [DW-1:0]     dk_in  [STEPS];
    logic [DW-1:0]     dk_reg [STEPS];
    logic [LANES-1:0]  sat_load;
    logic [LANES-1:0]  sat_reg [STEPS];
    logic [STEPS-1:0]  vld_reg;
    rti_pkg::reason_t  reason_reg [STEPS];
    logic [DW-1:0]     dsat;
    rti_pkg::wide_t    num [LANES];
    logic              hit_f;
    logic              u_clip;
    logic              v_clip;
    logic              done_reg;
    logic              hit_reg;
    logic [2:0]        reason_o_reg;
    logic [QW-1:0]     t_reg;
    logic [BW-1:0]     u_reg;
    logic [BW-1:0]     v_reg;

    always_comb
    begin
        num[0] = nt;
        num[1] = nu;
        num[2] = nv;
        dsat   = DW'({d, {QW{1'b0}}});
        dk_in[0] = DW'({d, {(QW-1){1'b0}}});
        for (int l = 0; l < LANES; l++)
        begin
            r_in[0][l]  = DW'({num[l], {rti_pkg::FRAC_BITS{1'b0}}});
            q_in[0][l]  = '0;
            sat_load[l] = r_in[0][l] >= dsat;
        end
        for (int i = 1; i < STEPS; i++)
        begin
            dk_in[i] = dk_reg[i-1];
            for (int l = 0; l < LANES; l++)
            begin
                r_in[i][l] = r_reg[i-1][l];
                q_in[i][l] = q_reg[i-1][l];
            end
        end
        for (int i = 0; i < STEPS; i++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                ge[i][l]     = r_in[i][l] >= dk_in[i];
                r_next[i][l] = ge[i][l] ? (r_in[i][l] - dk_in[i]) : r_in[i][l];
                q_next[i][l] = {q_in[i][l][QW-2:0], ge[i][l]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[STEPS-2:0], ctl.valid};
            done_reg <= vld_reg[STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < STEPS; i++)
        begin
            dk_reg[i] <= dk_in[i] >> 1;
            for (int l = 0; l < LANES; l++)
            begin
                r_reg[i][l] <= r_next[i][l];
                q_reg[i][l] <= q_next[i][l];
            end
        end
        sat_reg[0]    <= sat_load;
        reason_reg[0] <= ctl.reason;
        for (int i = 1; i < STEPS; i++)
        begin
            sat_reg[i]    <= sat_reg[i-1];
            reason_reg[i] <= reason_reg[i-1];
        end
    end

    always_comb
    begin
        hit_f  = reason_reg[STEPS-1] == rti_pkg::RSN_HIT;
        u_clip = sat_reg[STEPS-1][1] || (q_reg[STEPS-1][1][QW-1:BW] != '0);
        v_clip = sat_reg[STEPS-1][2] || (q_reg[STEPS-1][2][QW-1:BW] != '0);
    end

    always_ff @(posedge clk)
    begin
        hit_reg      <= hit_f;
        reason_o_reg <= reason_reg[STEPS-1];
        if (!hit_f)
        begin
            t_reg <= '0;
            u_reg <= '0;
            v_reg <= '0;
        end
        else
        begin
            t_reg <= sat_reg[STEPS-1][0] ? {QW{1'b1}} : q_reg[STEPS-1][0];
            u_reg <= u_clip ? {BW{1'b1}} : q_reg[STEPS-1][1][BW-1:0];
            v_reg <= v_clip ? {BW{1'b1}} : q_reg[STEPS-1][2][BW-1:0];
        end
    end

    assign done         = done_reg;
    assign hit          = hit_reg;
    assign miss_reason  = reason_o_reg;
    assign hit_distance = t_reg;
    assign bary_u       = u_reg;
    assign bary_v       = v_reg;

endmodule

// ===== rtl/ray_triangle_intersect.sv =====
// top level of the pipelined ray/triangle intersection unit
`timescale 1ns / 1ps

// Ray/triangle intersection test, one triangle per request.
// Configuration: write cfg_data to register cfg_index while cfg_we is high
// (0..2 origin, 3..5 direction, 6 minimum |det|), only while no request is
// in flight. Indexes beyond 6 are ignored.
// Requests: a triangle on the vertex ports is taken at each clock edge with
// start high and busy low. busy is always low: the pipeline takes a new
// triangle every cycle.
// Results: done is high for one cycle with hit, miss_reason, hit_distance,
// bary_u and bary_v, in request order. The path runs through 7 stages of
// edge/cross/dot products (two-stage partial-product multipliers), 3 stages
// of tests and 31 stages of one-bit restoring division for t, u and v, then
// an output register.
// Throughput: one result per cycle, sustained.
// Reset clears all in-flight requests and loads the ray (origin 0,
// direction +z, minimum |det| one LSB). There is no output stall.

module ray_triangle_intersect (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [rti_pkg::COORD_WIDTH-1:0]       vertex_a_x,
    input  logic [rti_pkg::COORD_WIDTH-1:0]       vertex_a_y,
    input  logic [rti_pkg::COORD_WIDTH-1:0]       vertex_a_z,
    input  logic [rti_pkg::COORD_WIDTH-1:0]       vertex_b_x,
    input  logic [rti_pkg::COORD_WIDTH-1:0]       vertex_b_y,
    input  logic [rti_pkg::COORD_WIDTH-1:0]       vertex_b_z,
    input  logic [rti_pkg::COORD_WIDTH-1:0]       vertex_c_x,
    input  logic [rti_pkg::COORD_WIDTH-1:0]       vertex_c_y,
    input  logic [rti_pkg::COORD_WIDTH-1:0]       vertex_c_z,
    input  logic                                  cfg_we,
    input  logic [rti_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [rti_pkg::COORD_WIDTH-1:0]       cfg_data,
    output logic                                  done,
    output logic                                  hit,
    output logic [2:0]                            miss_reason,
    output logic [rti_pkg::QUOT_WIDTH-1:0]        hit_distance,
    output logic [rti_pkg::BARY_WIDTH-1:0]        bary_u,
    output logic [rti_pkg::BARY_WIDTH-1:0]        bary_v
);

    localparam int LATENCY = 42;

    rti_pkg::ray_t                     ray_reg;
    logic [rti_pkg::THR_WIDTH-1:0]     min_det_reg;
    logic                              accept;
    rti_pkg::vec_t                     va;
    rti_pkg::vec_t                     vb;
    rti_pkg::vec_t                     vc;
    logic                              geo_valid;
    rti_pkg::wide_t                    geo_det;
    rti_pkg::wide_t                    geo_nu;
    rti_pkg::wide_t                    geo_nv;
    rti_pkg::wide_t                    geo_nt;
    rti_pkg::cls_t                     cls_ctl;
    rti_pkg::wide_t                    cls_det;
    rti_pkg::wide_t                    cls_nu;
    rti_pkg::wide_t                    cls_nv;
    rti_pkg::wide_t                    cls_nt;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign va = '{x: vertex_a_x, y: vertex_a_y, z: vertex_a_z};
    assign vb = '{x: vertex_b_x, y: vertex_b_y, z: vertex_b_z};
    assign vc = '{x: vertex_c_x, y: vertex_c_y, z: vertex_c_z};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ray_reg.origin.x <= '0;
            ray_reg.origin.y <= '0;
            ray_reg.origin.z <= '0;
            ray_reg.dir.x    <= '0;
            ray_reg.dir.y    <= '0;
            ray_reg.dir.z    <= rti_pkg::COORD_WIDTH'(2 ** rti_pkg::FRAC_BITS);
            min_det_reg      <= rti_pkg::THR_WIDTH'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rti_pkg::CFG_ORIGIN_X: ray_reg.origin.x <= cfg_data;
                rti_pkg::CFG_ORIGIN_Y: ray_reg.origin.y <= cfg_data;
                rti_pkg::CFG_ORIGIN_Z: ray_reg.origin.z <= cfg_data;
                rti_pkg::CFG_DIR_X:    ray_reg.dir.x    <= cfg_data;
                rti_pkg::CFG_DIR_Y:    ray_reg.dir.y    <= cfg_data;
                rti_pkg::CFG_DIR_Z:    ray_reg.dir.z    <= cfg_data;
                rti_pkg::CFG_MIN_DET:  min_det_reg <= cfg_data[rti_pkg::THR_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    rti_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .va        (va),
        .vb        (vb),
        .vc        (vc),
        .ray       (ray_reg),
        .out_valid (geo_valid),
        .det       (geo_det),
        .nu        (geo_nu),
        .nv        (geo_nv),
        .nt        (geo_nt)
    );

    rti_classify u_classify (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (geo_valid),
        .det         (geo_det),
        .nu          (geo_nu),
        .nv          (geo_nv),
        .nt          (geo_nt),
        .min_abs_det (min_det_reg),
        .ctl         (cls_ctl),
        .adet        (cls_det),
        .nu_out      (cls_nu),
        .nv_out      (cls_nv),
        .nt_out      (cls_nt)
    );

    rti_div u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (cls_ctl),
        .d            (cls_det),
        .nt           (cls_nt),
        .nu           (cls_nu),
        .nv           (cls_nv),
        .done         (done),
        .hit          (hit),
        .miss_reason  (miss_reason),
        .hit_distance (hit_distance),
        .bary_u       (bary_u),
        .bary_v       (bary_v)
    );

    // every request yields its result after the fixed pipeline depth
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("result missing after request");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without a request");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hit == (miss_reason == rti_pkg::RSN_HIT)))
        else $error("hit flag disagrees with miss reason");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (hit_distance == '0 && bary_u == '0 && bary_v == '0))
        else $error("nonzero payload on a miss");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> (({1'b0, bary_u} + {1'b0, bary_v})
            <= (rti_pkg::BARY_WIDTH+1)'(2 ** rti_pkg::FRAC_BITS)))
        else $error("barycentrics sum above one");

endmodule

// ===== tb/sv/tb_ray_triangle_intersect.sv =====
// testbench for the ray/triangle intersection unit with a built-in exact predictor
`timescale 1ns / 1ps

module tb_ray_triangle_intersect;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 60;
    localparam logic [rti_pkg::CFG_INDEX_WIDTH-1:0] CFG_UNUSED = 3'd7;
    localparam rti_pkg::coord_t ONE  = 32'sh0001_0000;
    localparam rti_pkg::coord_t CMAX = 32'sh7fff_ffff;
    localparam rti_pkg::coord_t CMIN = 32'sh8000_0000;

    typedef logic signed [191:0] acc_t;

    typedef struct {
        rti_pkg::coord_t v [9];
    } tri_t;

    typedef struct {
        logic                           hit;
        rti_pkg::reason_t               reason;
        logic [rti_pkg::QUOT_WIDTH-1:0] tdist;
        logic [rti_pkg::BARY_WIDTH-1:0] u;
        logic [rti_pkg::BARY_WIDTH-1:0] v;
    } isect_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    rti_pkg::coord_t vertex_a_x = '0, vertex_a_y = '0, vertex_a_z = '0;
    rti_pkg::coord_t vertex_b_x = '0, vertex_b_y = '0, vertex_b_z = '0;
    rti_pkg::coord_t vertex_c_x = '0, vertex_c_y = '0, vertex_c_z = '0;
    logic cfg_we = 1'b0;
    logic [rti_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [rti_pkg::COORD_WIDTH-1:0] cfg_data = '0;
    logic done, hit;
    logic [2:0] miss_reason;
    logic [rti_pkg::QUOT_WIDTH-1:0] hit_distance;
    logic [rti_pkg::BARY_WIDTH-1:0] bary_u, bary_v;

    // mirror of the ray registers
    rti_pkg::coord_t ray_org [3];
    rti_pkg::coord_t ray_dir [3];
    logic [rti_pkg::THR_WIDTH-1:0] min_det;

    tri_t   tri_queue [$];
    isect_t hit_queue [$];
    int     error_count = 0;
    bit     no_idle = 0;
    int     gap_left = 0;
    int     quiet_cycles = 0;

    ray_triangle_intersect uut (.*);

    always #5 clk = ~clk;

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        error_count++;
    endtask

    // floor(n * 2^FRAC_BITS / d), saturated to nbits
    function automatic logic [63:0] frac_quot(input acc_t n, input acc_t d, input int nbits);
        acc_t q;
        q = (n <<< rti_pkg::FRAC_BITS) / d;
        if (q >= (acc_t'(1) <<< nbits))
            return (64'd1 << nbits) - 64'd1;
        return q[63:0];
    endfunction

    function automatic isect_t predict(input tri_t t);
        acc_t a [3], e1 [3], e2 [3], s [3], d [3], p [3], q [3];
        acc_t det, nu, nv, nt, thr;
        isect_t r;
        for (int i = 0; i < 3; i++)
        begin
            a[i]  = acc_t'(t.v[i]);
            e1[i] = acc_t'(t.v[3+i]) - a[i];
            e2[i] = acc_t'(t.v[6+i]) - a[i];
            s[i]  = acc_t'(ray_org[i]) - a[i];
            d[i]  = acc_t'(ray_dir[i]);
        end
        p[0] = d[1]*e2[2] - d[2]*e2[1];
        p[1] = d[2]*e2[0] - d[0]*e2[2];
        p[2] = d[0]*e2[1] - d[1]*e2[0];
        q[0] = s[1]*e1[2] - s[2]*e1[1];
        q[1] = s[2]*e1[0] - s[0]*e1[2];
        q[2] = s[0]*e1[1] - s[1]*e1[0];
        det = e1[0]*p[0] + e1[1]*p[1] + e1[2]*p[2];
        nu  = s[0]*p[0] + s[1]*p[1] + s[2]*p[2];
        nv  = d[0]*q[0] + d[1]*q[1] + d[2]*q[2];
        nt  = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
        if (det < 0)
        begin
            det = -det;
            nu = -nu;
            nv = -nv;
            nt = -nt;
        end
        // det has three times the fraction bits of the threshold
        thr = acc_t'({1'b0, min_det}) <<< (2 * rti_pkg::FRAC_BITS);
        r = '{1'b0, rti_pkg::RSN_HIT, '0, '0, '0};
        if (det == 0 || det < thr)
            r.reason = rti_pkg::RSN_PARALLEL;
        else if (nu < 0 || nu > det)
            r.reason = rti_pkg::RSN_U_OUT;
        else if (nv < 0 || nu + nv > det)
            r.reason = rti_pkg::RSN_V_OUT;
        else if ((nt <<< rti_pkg::FRAC_BITS) < det)
            r.reason = rti_pkg::RSN_BEHIND;
        else
        begin
            r.hit   = 1'b1;
            r.tdist = rti_pkg::QUOT_WIDTH'(frac_quot(nt, det, rti_pkg::QUOT_WIDTH));
            r.u     = rti_pkg::BARY_WIDTH'(frac_quot(nu, det, rti_pkg::BARY_WIDTH));
            r.v     = rti_pkg::BARY_WIDTH'(frac_quot(nv, det, rti_pkg::BARY_WIDTH));
        end
        return r;
    endfunction

    // request driver
    always @(posedge clk)
    begin
        tri_t t;
        if (start && !busy)
        begin
            t.v = '{vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
                    vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z};
            hit_queue = {hit_queue, predict(t)};
        end
        if (!start || !busy)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else if (tri_queue.size() > 0)
            begin
                t = tri_queue.pop_front();
                {vertex_a_x, vertex_a_y, vertex_a_z} <= {t.v[0], t.v[1], t.v[2]};
                {vertex_b_x, vertex_b_y, vertex_b_z} <= {t.v[3], t.v[4], t.v[5]};
                {vertex_c_x, vertex_c_y, vertex_c_z} <= {t.v[6], t.v[7], t.v[8]};
                start <= 1'b1;
                if (!no_idle && $urandom_range(0, 9) == 0)
                    gap_left <= $urandom_range(1, 19);
            end
            else
                start <= 1'b0;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        isect_t e;
        if (done)
        begin
            if (hit_queue.size() == 0)
                report("result with no request outstanding");
            else
            begin
                e = hit_queue.pop_front();
                if (hit !== e.hit)
                    report($sformatf("hit %0b, expected %0b", hit, e.hit));
                if (miss_reason !== e.reason)
                    report($sformatf("miss_reason %0d, expected %0d", miss_reason, e.reason));
                if (hit_distance !== e.tdist)
                    report($sformatf("hit_distance %h, expected %h", hit_distance, e.tdist));
                if (bary_u !== e.u)
                    report($sformatf("bary_u %h, expected %h", bary_u, e.u));
                if (bary_v !== e.v)
                    report($sformatf("bary_v %h, expected %h", bary_v, e.v));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_we || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // writes all ray registers back to back, plus one unused index
    task automatic load_ray(input rti_pkg::coord_t ox, oy, oz, dx, dy, dz,
                            input logic [rti_pkg::THR_WIDTH-1:0] md);
        logic [rti_pkg::COORD_WIDTH-1:0] vals [8];
        vals = '{ox, oy, oz, dx, dy, dz, {1'b1, md}, 32'hdead_beef};
        for (int i = 0; i < 8; i++)
        begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= (i == 7) ? CFG_UNUSED
                                  : rti_pkg::CFG_ORIGIN_X + rti_pkg::CFG_INDEX_WIDTH'(i);
            cfg_data <= vals[i];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        ray_org = '{ox, oy, oz};
        ray_dir = '{dx, dy, dz};
        min_det = md;
    endtask

    task automatic wait_idle();
        while (tri_queue.size() > 0 || start || hit_queue.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic push_tri(input rti_pkg::coord_t ax, ay, az, bx, by, bz, cx, cy, cz);
        tri_t t;
        t.v = '{ax, ay, az, bx, by, bz, cx, cy, cz};
        tri_queue = {tri_queue, t};
    endtask

    function automatic rti_pkg::coord_t jitter(input int k);
        return rti_pkg::coord_t'(int'($urandom_range(0, (2 << k) - 1)) - (1 << k));
    endfunction

    function automatic rti_pkg::coord_t any_coord();
        return rti_pkg::coord_t'($urandom());
    endfunction

    // mostly triangles laid across the ray, some full-range noise
    task automatic random_tris(input int count);
        tri_t t;
        int k;
        rti_pkg::coord_t cz;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 4) == 0)
                for (int i = 0; i < 9; i++) t.v[i] = any_coord();
            else
            begin
                k = $urandom_range(2, 24);
                cz = jitter($urandom_range(4, 26));
                for (int j = 0; j < 3; j++)
                begin
                    t.v[3*j]   = ray_org[0] + jitter(k) + ((cz >>> 16) * (ray_dir[0] >>> 16));
                    t.v[3*j+1] = ray_org[1] + jitter(k) + ((cz >>> 16) * (ray_dir[1] >>> 16));
                    t.v[3*j+2] = ray_org[2] + cz + jitter(k - 2);
                end
            end
            tri_queue = {tri_queue, t};
        end
    endtask

    function automatic rti_pkg::coord_t small_dir();
        return rti_pkg::coord_t'(int'($urandom_range(0, 4 << 16)) - (2 << 16));
    endfunction

    initial
    begin
        ray_org = '{0, 0, 0};
        ray_dir = '{0, 0, ONE};
        min_det = 31'd1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset ray along +z
        push_tri(0, 0, 5*ONE, ONE, 0, 5*ONE, 0, ONE, 5*ONE);
        push_tri(0, 0, 5*ONE, ONE, 0, 5*ONE, 0, 0, 7*ONE);
        push_tri(-ONE, -ONE, 3*ONE, ONE, 0, 3*ONE, 0, ONE, 3*ONE);
        push_tri(ONE, 0, 3*ONE, 2*ONE, 0, 3*ONE, ONE, ONE, 3*ONE);
        push_tri(0, ONE, 3*ONE, ONE, ONE, 3*ONE, 0, 2*ONE, 3*ONE);
        push_tri(-ONE, 0, 3*ONE, ONE, -ONE, 3*ONE, ONE, ONE, 3*ONE);
        push_tri(0, 0, -5*ONE, ONE, 0, -5*ONE, 0, ONE, -5*ONE);
        push_tri(0, 0, 0, ONE, 0, 0, 0, ONE, 0);
        push_tri(-ONE, -ONE, 1, ONE, -ONE, 1, 0, ONE, 1);
        push_tri(0, 0, 2*ONE, 0, 0, 2*ONE, 0, 0, 2*ONE);
        push_tri(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMAX);
        push_tri(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMIN);
        push_tri(-ONE, -ONE, CMAX, 2*ONE, 0, CMAX, 0, 2*ONE, CMAX);
        push_tri(-1, -1, 9*ONE, 1, 0, 9*ONE, 0, 1, 9*ONE);
        wait_idle();

        // ray through a vertex, u exactly one
        load_ray(ONE, 0, 0, 0, 0, ONE, 31'd0);
        push_tri(0, 0, 4*ONE, ONE, 0, 4*ONE, 0, ONE, 4*ONE);
        push_tri(0, -ONE, 4*ONE, ONE, ONE, 4*ONE, 0, ONE, 4*ONE);
        wait_idle();

        // far origin so t saturates
        load_ray(0, 0, CMIN, 0, 0, 1, 31'd0);
        push_tri(-ONE, -ONE, CMAX, ONE, -ONE, CMAX, 0, ONE, CMAX);
        push_tri(-2, -2, CMAX, 2, -2, CMAX, 0, 2, CMAX);
        wait_idle();

        // largest minimum |det|, so small triangles are parallel
        load_ray(0, 0, 0, ONE, ONE, ONE, 31'h7fff_ffff);
        push_tri(-ONE, -ONE, 3*ONE, ONE, 0, 3*ONE, 0, ONE, 3*ONE);
        random_tris(60);
        wait_idle();

        for (int ph = 0; ph < 7; ph++)
        begin
            unique case (ph)
                0: load_ray(0, 0, 0, 0, 0, ONE, 31'd1);
                1: load_ray(jitter(20), jitter(20), jitter(20),
                            small_dir(), small_dir(), small_dir(), 31'd0);
                2: load_ray(CMAX, CMIN, CMAX, CMAX, CMIN, CMAX, 31'd1);
                3: load_ray(jitter(24), jitter(24), jitter(24), 0, ONE, 0,
                            31'($urandom_range(0, 1 << 16)));
                4: load_ray(any_coord(), any_coord(), any_coord(),
                            any_coord(), any_coord(), any_coord(), 31'($urandom()));
                5: load_ray(0, 0, 0, small_dir(), small_dir(), -ONE, 31'd0);
                default:
                begin
                    load_ray(jitter(18), jitter(18), jitter(18),
                             small_dir(), small_dir(), small_dir(), 31'd16);
                    no_idle = 1;
                end
            endcase
            random_tris(230);
            wait_idle();
        end

        if (hit_queue.size() != 0)
            report("results still outstanding at end of run");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rti_pkg.sv
rtl/rti_mul.sv
rtl/rti_geom.sv
rtl/rti_classify.sv
rtl/rti_div.sv
rtl/ray_triangle_intersect.sv
tb/sv/tb_ray_triangle_intersect.sv
